### rtl/tsrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrq_pkg - temperature sensor reading qualifier shared definitions
// Item kinds, error codes, limits, CRC-8 helpers and the check result type.
// ----------------------------------------------------------------------------
package tsrq_pkg;

  // Widths
  localparam int AGE_BITS = 20;
  localparam int STALE_W  = 20;
  localparam int FAIL_W   = 8;
  localparam int CMP_W    = (AGE_BITS > STALE_W) ? AGE_BITS : STALE_W;

  // Limits and reset values
  localparam logic [AGE_BITS-1:0] AGE_MAX          = '1;
  localparam logic [AGE_BITS-1:0] AGE_ONE          = AGE_BITS'(1);
  localparam logic [STALE_W-1:0]  STALE_RESET      = STALE_W'(60000);
  localparam logic [FAIL_W-1:0]   FAIL_LIMIT_RESET = FAIL_W'(15);
  localparam logic [FAIL_W-1:0]   STREAK_MAX       = FAIL_W'(255);
  localparam logic signed [15:0]  RAW_LOW_EXCL     = -16'sd640;
  localparam logic signed [15:0]  RAW_HIGH_EXCL    = 16'sd1360;
  localparam logic [7:0]          CRC_POLY         = 8'h8C;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_TICK        = 2'd0,
    KIND_READING     = 2'd1,
    KIND_NO_PRESENCE = 2'd2,
    KIND_UNUSED      = 2'd3
  } kind_e;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_PRESENCE = 3'd1,
    ERR_CRC         = 3'd2,
    ERR_RANGE       = 3'd3,
    ERR_IMPLAUSIBLE = 3'd4
  } err_code_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_STALE_AFTER = 1'b0,
    CFG_FAIL_LIMIT  = 1'b1
  } cfg_idx_e;

  // Outcome of checking one scratchpad
  typedef struct packed {
    err_code_e          err;
    logic signed [11:0] tenths;
  } check_t;

  // Bit-serial Maxim CRC-8 (reflected, init 0); used only at elaboration
  function automatic logic [7:0] crc8_serial_f(input logic [63:0] msg);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 8; i++) begin
      crc ^= msg[i*8 +: 8];
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // CRC contribution of each message bit (CRC is linear with zero init)
  function automatic logic [63:0][7:0] crc_cols_f();
    logic [63:0][7:0] cols;
    for (int p = 0; p < 64; p++) begin
      cols[p] = crc8_serial_f(64'd1 << p);
    end
    return cols;
  endfunction

  localparam logic [63:0][7:0] CRC_COLS = crc_cols_f();

  // Parallel CRC-8: XOR of the columns of the set bits
  function automatic logic [7:0] crc8_f(input logic [63:0] msg);
    logic [7:0] crc;
    crc = '0;
    for (int p = 0; p < 64; p++) begin
      if (msg[p]) crc ^= CRC_COLS[p];
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

### rtl/tsrq_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrq_check - scratchpad check and temperature conversion
// CRC, range and plausibility checks in priority order, plus the conversion
// of the raw 1/16 degree value to tenths rounded half away from zero.
// ----------------------------------------------------------------------------
module tsrq_check (
  input  wire logic [63:0]        scratch_i,
  input  wire logic [7:0]         crc_i,
  output tsrq_pkg::check_t        check_o,
  output logic signed [15:0]      raw_o
);

  logic               crc_ok;
  logic               in_range;
  logic               implausible;
  logic signed [15:0] raw;
  logic [15:0]        mag_full;
  logic [10:0]        mag;
  logic [13:0]        scaled;
  logic signed [11:0] tpos;

  assign raw   = signed'(scratch_i[15:0]);
  assign raw_o = raw;

  // Checks
  assign crc_ok      = (tsrq_pkg::crc8_f(scratch_i) == crc_i);
  assign in_range    = (raw > tsrq_pkg::RAW_LOW_EXCL) && (raw < tsrq_pkg::RAW_HIGH_EXCL);
  assign implausible = (scratch_i[31:0] == 32'd0) || (raw == 16'sd0);

  // tenths = (5*|raw| + 4) >> 3; magnitude fits 11 bits inside the range
  assign mag_full = raw[15] ? (16'd0 - scratch_i[15:0]) : scratch_i[15:0];
  assign mag      = mag_full[10:0];
  assign scaled   = {1'b0, mag, 2'b00} + {3'b000, mag} + 14'd4;
  assign tpos     = {2'b00, scaled[12:3]};

  // Priority of error reporting
  always_comb begin
    check_o.tenths = raw[15] ? -tpos : tpos;
    priority if (!crc_ok) begin
      check_o.err = tsrq_pkg::ERR_CRC;
    end else if (!in_range) begin
      check_o.err = tsrq_pkg::ERR_RANGE;
    end else if (implausible) begin
      check_o.err = tsrq_pkg::ERR_IMPLAUSIBLE;
    end else begin
      check_o.err = tsrq_pkg::ERR_NONE;
    end
  end

endmodule
`default_nettype wire

### rtl/temp_sensor_reading_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// temp_sensor_reading_qualifier - scratchpad decode and live tracking
// Qualifies ticks, readings and no-presence events; keeps the last good
// temperature, the fail streak, the age since the last good reading and live.
// ----------------------------------------------------------------------------
// Usage: one item per transaction on the input channel, exactly one result per
// item on the output channel, in order. The block accepts one item every
// cycle unless the output side holds back a result; each item passes through the
// input register, then the result register. The whole check and state update sits in
// one combinational pass between those two registers, so throughput is one
// item per clock as long as the output side takes results; in_ready_o follows
// out_ready_i combinationally. Configuration writes are never held off
// (cfg_ready_o is always high) and should be issued only while no item is in
// flight. There is no memory and no initialization pass after reset.
// ----------------------------------------------------------------------------
module temp_sensor_reading_qualifier (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [19:0]         cfg_data_i,
  // Input item channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          kind_i,
  input  wire logic [7:0]          scratch_byte0_i,
  input  wire logic [7:0]          scratch_byte1_i,
  input  wire logic [7:0]          scratch_byte2_i,
  input  wire logic [7:0]          scratch_byte3_i,
  input  wire logic [7:0]          scratch_byte4_i,
  input  wire logic [7:0]          scratch_byte5_i,
  input  wire logic [7:0]          scratch_byte6_i,
  input  wire logic [7:0]          scratch_byte7_i,
  input  wire logic [7:0]          scratch_crc_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     live_o,
  output logic signed [10:0]       temp_tenths_o,
  output logic                     reading_ok_o,
  output logic [2:0]               error_code_o,
  output logic [7:0]               fail_count_o,
  output logic signed [15:0]       raw_sixteenths_o
);

  // Configuration registers
  logic [tsrq_pkg::STALE_W-1:0] stale_q;
  logic [tsrq_pkg::FAIL_W-1:0]  fail_limit_q;

  // Tracking state
  logic [tsrq_pkg::FAIL_W-1:0]   streak_q, streak_d;
  logic                          live_q, live_d;
  logic [tsrq_pkg::AGE_BITS-1:0] age_q, age_d;
  logic signed [11:0]            held_q, held_d;

  // Input register
  logic        s1_valid_q;
  logic [1:0]  s1_kind_q;
  logic [63:0] s1_scratch_q;
  logic [7:0]  s1_crc_q;
  logic        s1_adv;

  // Result register
  logic                     out_valid_q;
  logic                     ok_d;
  tsrq_pkg::err_code_e      err_d;
  logic signed [15:0]       raw_d;

  tsrq_pkg::check_t         check;
  logic signed [15:0]       check_raw;
  logic [tsrq_pkg::FAIL_W-1:0]   streak_inc;
  logic [tsrq_pkg::AGE_BITS-1:0] age_inc;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign out_valid_o = out_valid_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q      <= tsrq_pkg::STALE_RESET;
      fail_limit_q <= tsrq_pkg::FAIL_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (tsrq_pkg::cfg_idx_e'(cfg_index_i))
        tsrq_pkg::CFG_STALE_AFTER: stale_q      <= cfg_data_i;
        tsrq_pkg::CFG_FAIL_LIMIT:  fail_limit_q <= cfg_data_i[tsrq_pkg::FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q    <= kind_i;
      s1_scratch_q <= {scratch_byte7_i, scratch_byte6_i, scratch_byte5_i, scratch_byte4_i,
                       scratch_byte3_i, scratch_byte2_i, scratch_byte1_i, scratch_byte0_i};
      s1_crc_q     <= scratch_crc_i;
    end
  end

  // Scratchpad check
  tsrq_check u_check (
    .scratch_i (s1_scratch_q),
    .crc_i     (s1_crc_q),
    .check_o   (check),
    .raw_o     (check_raw)
  );

  // Saturating counters
  assign streak_inc = (streak_q != tsrq_pkg::STREAK_MAX) ? streak_q + tsrq_pkg::FAIL_W'(1)
                                                         : streak_q;
  assign age_inc    = (age_q != tsrq_pkg::AGE_MAX) ? age_q + tsrq_pkg::AGE_ONE : age_q;

  // Next state and result for the item in the input register
  always_comb begin
    streak_d = streak_q;
    live_d   = live_q;
    age_d    = age_q;
    held_d   = held_q;
    ok_d     = 1'b0;
    err_d    = tsrq_pkg::ERR_NONE;
    raw_d    = 16'sd0;
    unique case (tsrq_pkg::kind_e'(s1_kind_q))
      tsrq_pkg::KIND_TICK: begin
        age_d = age_inc;
        if (live_q && (tsrq_pkg::CMP_W'(age_inc) > tsrq_pkg::CMP_W'(stale_q))) begin
          live_d = 1'b0;
        end
      end
      tsrq_pkg::KIND_READING: begin
        raw_d = check_raw;
        err_d = check.err;
        if (check.err == tsrq_pkg::ERR_NONE) begin
          ok_d     = 1'b1;
          streak_d = '0;
          live_d   = 1'b1;
          age_d    = '0;
          held_d   = check.tenths;
        end else begin
          streak_d = streak_inc;
          if (streak_inc >= fail_limit_q) live_d = 1'b0;
        end
      end
      tsrq_pkg::KIND_NO_PRESENCE: begin
        err_d    = tsrq_pkg::ERR_NO_PRESENCE;
        streak_d = streak_inc;
        if (streak_inc >= fail_limit_q) live_d = 1'b0;
      end
      tsrq_pkg::KIND_UNUSED: ;
      default: ;
    endcase
  end

  // State commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q <= '0;
      live_q   <= 1'b0;
      age_q    <= '0;
      held_q   <= '0;
    end else if (s1_adv) begin
      streak_q <= streak_d;
      live_q   <= live_d;
      age_q    <= age_d;
      held_q   <= held_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      live_o           <= live_d;
      temp_tenths_o    <= held_d[10:0];
      reading_ok_o     <= ok_d;
      error_code_o     <= err_d;
      fail_count_o     <= streak_d;
      raw_sixteenths_o <= raw_d;
    end
  end

  // Assertions
  a_ok_means_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reading_ok_o |->
      live_o && (fail_count_o == 8'd0) && (error_code_o == tsrq_pkg::ERR_NONE))
    else $error("accepted reading without live, zero streak and no error");

  a_fail_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != tsrq_pkg::ERR_NONE) |->
      (fail_count_o != 8'd0) && !reading_ok_o)
    else $error("failed item did not raise the fail streak");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_kind_q) && $stable(s1_scratch_q))
    else $error("stalled item in input register was lost or overwritten");

endmodule
`default_nettype wire

### test/temp_sensor_reading_qualifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_sensor_reading_qualifier_tb - self-checking bench for the qualifier
// Runs a short directed table (reset state, range edges, every error path,
// rounding), then random ticks, readings and failures under several register
// settings and handshake stall patterns. Each result is checked in order
// against its table row or a cycle-free model of the qualifier kept in the bench.
// ----------------------------------------------------------------------------
module temp_sensor_reading_qualifier_tb;
  import tsrq_pkg::*;

  localparam int HALF_NS        = 5;
  localparam int SETTLE_CYCLES  = 4;
  localparam int ITEMS_PER_SET  = 106;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_NS     = 2_000_000;
  localparam logic signed [15:0] RAW_FLOOR = -16'sd640;
  localparam logic signed [15:0] RAW_CEIL  = 16'sd1360;
  localparam logic [19:0]        AGE_TOP   = 20'hFFFFF;
  localparam logic [7:0]         STREAK_TOP = 8'd255;

  // One input item and one result as seen on the ports
  typedef struct packed {
    kind_e            kind;
    logic [7:0][7:0]  b;      // b[0] is scratchpad byte 0
    logic [7:0]       crc;
  } scratch_item_t;

  typedef struct packed {
    logic               live;
    logic signed [10:0] tenths;
    logic               ok;
    err_code_e          err;
    logic [7:0]         fail;
    logic signed [15:0] raw;
  } qual_result_t;

  typedef struct {
    scratch_item_t item;
    bit            typed;
    qual_result_t  res;
  } table_row_t;

  // Clock, reset and port signals
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_e           cfg_index = CFG_STALE_AFTER;
  logic [19:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  scratch_item_t      drv = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               live;
  logic signed [10:0] temp_tenths;
  logic               reading_ok;
  logic [2:0]         error_code;
  logic [7:0]         fail_count;
  logic signed [15:0] raw_sixteenths;

  // Model state and register copies
  logic [7:0]         m_streak = '0;
  logic               m_live = 1'b0;
  logic [19:0]        m_age = '0;
  logic signed [11:0] m_held = '0;
  logic [19:0]        m_stale = 20'd60000;
  logic [7:0]         m_limit = 8'd15;

  qual_result_t       pending_results[$];
  table_row_t         directed_rows[$];
  int                 mismatches = 0;
  int                 src_idle_pct = 36;
  int                 rcv_idle_pct = 54;
  int                 fail_run = 0;
  int                 tick_run = 0;

  temp_sensor_reading_qualifier u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (drv.kind),
    .scratch_byte0_i  (drv.b[0]),
    .scratch_byte1_i  (drv.b[1]),
    .scratch_byte2_i  (drv.b[2]),
    .scratch_byte3_i  (drv.b[3]),
    .scratch_byte4_i  (drv.b[4]),
    .scratch_byte5_i  (drv.b[5]),
    .scratch_byte6_i  (drv.b[6]),
    .scratch_byte7_i  (drv.b[7]),
    .scratch_crc_i    (drv.crc),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .live_o           (live),
    .temp_tenths_o    (temp_tenths),
    .reading_ok_o     (reading_ok),
    .error_code_o     (error_code),
    .fail_count_o     (fail_count),
    .raw_sixteenths_o (raw_sixteenths)
  );

  // 100 MHz clock
  always begin
    #(HALF_NS) clk = 1'b1;
    #(HALF_NS) clk = 1'b0;
  end

  // Maxim CRC-8, one message bit at a time, byte 0 bit 0 first
  function automatic logic [7:0] maxim_crc8(input logic [63:0] msg);
    logic [7:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 0; i < 64; i++) begin
      fb  = crc[0] ^ msg[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ 8'h8C;
    end
    return crc;
  endfunction

  // Failed or absent reading: bump the streak, drop live at the limit
  function automatic void count_failure();
    if (m_streak != STREAK_TOP) m_streak = m_streak + 8'd1;
    if (m_streak >= m_limit) m_live = 1'b0;
  endfunction

  // Expected result of one item; updates the model state
  function automatic qual_result_t qualify_item(input scratch_item_t it);
    qual_result_t       r;
    logic signed [15:0] raw;
    int                 mag;
    int                 t;
    r   = '0;
    raw = '0;
    case (it.kind)
      KIND_TICK: begin
        if (m_age != AGE_TOP) m_age = m_age + 20'd1;
        if (m_live && m_age > m_stale) m_live = 1'b0;
      end
      KIND_READING: begin
        raw = {it.b[1], it.b[0]};
        if (maxim_crc8(it.b) != it.crc) r.err = ERR_CRC;
        else if (!(raw > RAW_FLOOR && raw < RAW_CEIL)) r.err = ERR_RANGE;
        else if ({it.b[3], it.b[2], it.b[1], it.b[0]} == '0 || raw == 0)
          r.err = ERR_IMPLAUSIBLE;
        if (r.err == ERR_NONE) begin
          // tenths, rounded half away from zero
          mag      = (raw < 0) ? -int'(raw) : int'(raw);
          t        = (mag * 5 + 4) / 8;
          m_held   = 12'((raw < 0) ? -t : t);
          m_streak = '0;
          m_live   = 1'b1;
          m_age    = '0;
          r.ok     = 1'b1;
        end else begin
          count_failure();
        end
      end
      KIND_NO_PRESENCE: begin
        r.err = ERR_NO_PRESENCE;
        count_failure();
      end
      default: ;
    endcase
    r.live   = m_live;
    r.tenths = m_held[10:0];
    r.fail   = m_streak;
    r.raw    = raw;
    return r;
  endfunction

  function automatic qual_result_t mk_res(input bit lv, input int tenths, input bit ok,
                                          input err_code_e err, input int fail,
                                          input int raw);
    qual_result_t r;
    r.live   = lv;
    r.tenths = 11'(tenths);
    r.ok     = ok;
    r.err    = err;
    r.fail   = 8'(fail);
    r.raw    = 16'(raw);
    return r;
  endfunction

  // Item of any kind with a random scratchpad
  function automatic scratch_item_t plain_item(input kind_e kind);
    scratch_item_t it;
    it.kind = kind;
    it.b    = {$urandom, $urandom};
    it.crc  = 8'($urandom);
    return it;
  endfunction

  // Reading with a given temperature and alarm bytes, CRC right or wrong
  function automatic scratch_item_t build_reading(input logic [15:0] raw, input logic [7:0] b2,
                                                  input logic [7:0] b3, input bit good_crc);
    scratch_item_t it;
    it      = plain_item(KIND_READING);
    it.b[0] = raw[7:0];
    it.b[1] = raw[15:8];
    it.b[2] = b2;
    it.b[3] = b3;
    it.crc  = maxim_crc8(it.b);
    if (!good_crc) it.crc = it.crc ^ 8'($urandom_range(255, 1));
    return it;
  endfunction

  function automatic scratch_item_t good_item();
    return build_reading(16'(int'($urandom_range(1998)) - 639), 8'($urandom), 8'($urandom),
                         1'b1);
  endfunction

  function automatic scratch_item_t range_item();
    logic [15:0] raw;
    if ($urandom_range(1)) raw = 16'($urandom_range(32767, 1360));
    else raw = 16'(-int'($urandom_range(32768, 640)));
    return build_reading(raw, 8'($urandom), 8'($urandom), 1'b1);
  endfunction

  function automatic scratch_item_t implausible_item();
    if ($urandom_range(1)) return build_reading(16'd0, 8'd0, 8'd0, 1'b1);
    return build_reading(16'd0, 8'($urandom), 8'($urandom), 1'b1);
  endfunction

  function automatic scratch_item_t crc_error_item();
    return build_reading(16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endfunction

  function automatic scratch_item_t failure_item();
    case ($urandom_range(3))
      0:       return plain_item(KIND_NO_PRESENCE);
      1:       return crc_error_item();
      2:       return range_item();
      default: return implausible_item();
    endcase
  endfunction

  // Random traffic: mostly good readings and ticks, with runs of ticks to
  // age out the held value and runs of failures to reach the fail limit
  function automatic scratch_item_t random_item();
    int pick;
    if (fail_run > 0) begin
      fail_run--;
      return failure_item();
    end
    if (tick_run > 0) begin
      tick_run--;
      return plain_item(KIND_TICK);
    end
    pick = $urandom_range(99);
    if (pick < 3) begin
      fail_run = ($urandom_range(199) == 0) ? 300 : $urandom_range(20, 1);
      return failure_item();
    end
    if (pick < 6) begin
      tick_run = $urandom_range(40, 1);
      return plain_item(KIND_TICK);
    end
    if (pick < 36) return plain_item(KIND_TICK);
    if (pick < 66) return good_item();
    if (pick < 74) return plain_item(KIND_NO_PRESENCE);
    if (pick < 82) return crc_error_item();
    if (pick < 90) return range_item();
    if (pick < 96) return implausible_item();
    return plain_item(KIND_UNUSED);
  endfunction

  task automatic add_row(input scratch_item_t it, input bit typed, input qual_result_t res);
    table_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  // Drive one transaction; called and returns at a falling edge
  task automatic send_item(input scratch_item_t it, input bit typed, input qual_result_t res);
    qual_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    drv      = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = qualify_item(it);
    pending_results.push_back(typed ? res : pred);
    @(negedge clk);
  endtask

  // Wait until every result is back and the pipeline has emptied
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [19:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_STALE_AFTER) m_stale = data;
    else m_limit = data[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    qual_result_t want;
    qual_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {live, temp_tenths, reading_ok, err_code_e'(error_code), fail_count, raw_sixteenths};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: live=%0d tenths=%0d ok=%0d err=%0d fail=%0d raw=%0d",
                   $realtime, got.live, got.tenths, got.ok, got.err, got.fail, got.raw);
      end else begin
        want = pending_results.pop_front();
        if (got.live !== want.live || got.tenths !== want.tenths || got.ok !== want.ok ||
            got.err !== want.err || got.fail !== want.fail || got.raw !== want.raw) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp live=%0d tenths=%0d ok=%0d err=%0d fail=%0d raw=%0d | got live=%0d tenths=%0d ok=%0d err=%0d fail=%0d raw=%0d",
                     $realtime, want.live, want.tenths, want.ok, want.err, want.fail,
                     want.raw, got.live, got.tenths, got.ok, got.err, got.fail, got.raw);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin
    logic [19:0] stale_set [6];
    logic [19:0] limit_set [6];
    int          src_set   [3];
    int          rcv_set   [3];
    stale_set = '{20'd0, 20'd1, 20'd5, 20'd25, 20'd1000000, 20'd60000};
    // upper data bits beyond the 8-bit limit are dropped
    limit_set = '{20'h00000, 20'h00001, 20'hFFF03, 20'h000FF, 20'h000FF, 20'h0000F};
    src_set   = '{36, 54, 0};
    rcv_set   = '{54, 36, 0};

    // Directed table, reset register values (stale 60000, limit 15)
    add_row(plain_item(KIND_TICK), 1, mk_res(0, 0, 0, ERR_NONE, 0, 0));
    add_row(plain_item(KIND_NO_PRESENCE), 1, mk_res(0, 0, 0, ERR_NO_PRESENCE, 1, 0));
    add_row(plain_item(KIND_UNUSED), 1, mk_res(0, 0, 0, ERR_NONE, 1, 0));
    add_row(build_reading(16'h0000, 8'h00, 8'h00, 1), 1,
            mk_res(0, 0, 0, ERR_IMPLAUSIBLE, 2, 0));
    add_row(build_reading(16'h0550, 8'h4B, 8'h46, 0), 1, mk_res(0, 0, 0, ERR_CRC, 3, 1360));
    add_row(build_reading(16'h0550, 8'h4B, 8'h46, 1), 1,
            mk_res(0, 0, 0, ERR_RANGE, 4, 1360));
    add_row(build_reading(16'hFD80, 8'h4B, 8'h46, 1), 1,
            mk_res(0, 0, 0, ERR_RANGE, 5, -640));
    add_row(build_reading(16'h8000, 8'hFF, 8'hFF, 1), 1,
            mk_res(0, 0, 0, ERR_RANGE, 6, -32768));
    add_row(build_reading(16'h7FFF, 8'hFF, 8'hFF, 1), 1,
            mk_res(0, 0, 0, ERR_RANGE, 7, 32767));
    add_row(build_reading(16'h054F, 8'h4B, 8'h46, 1), 1,
            mk_res(1, 849, 1, ERR_NONE, 0, 1359));
    add_row(build_reading(16'hFD81, 8'h4B, 8'h46, 1), 1,
            mk_res(1, -399, 1, ERR_NONE, 0, -639));
    add_row(build_reading(16'h0001, 8'h00, 8'h00, 1), 1, mk_res(1, 1, 1, ERR_NONE, 0, 1));
    add_row(build_reading(16'hFFFF, 8'h4B, 8'h46, 1), 1,
            mk_res(1, -1, 1, ERR_NONE, 0, -1));
    // raw zero with nonzero alarm bytes is still implausible
    add_row(build_reading(16'h0000, 8'h4B, 8'h46, 1), 1,
            mk_res(1, -1, 0, ERR_IMPLAUSIBLE, 1, 0));
    // exact halves round away from zero; the rows below are checked against the model
    add_row(build_reading(16'h0004, 8'h4B, 8'h46, 1), 0, '0);
    add_row(build_reading(16'hFFFC, 8'h4B, 8'h46, 1), 0, '0);
    add_row(build_reading(16'h000C, 8'h4B, 8'h46, 1), 0, '0);
    add_row(build_reading(16'h0191, 8'h4B, 8'h46, 1), 0, '0);
    add_row(plain_item(KIND_UNUSED), 0, '0);
    add_row(plain_item(KIND_NO_PRESENCE), 0, '0);
    add_row(plain_item(KIND_TICK), 0, '0);
    add_row(build_reading(16'hFFF6, 8'hA5, 8'h5A, 0), 0, '0);

    // Reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    drain();

    // Random traffic over every stall pattern and register setting
    for (int m = 0; m < 3; m++) begin
      src_idle_pct = src_set[m];
      rcv_idle_pct = rcv_set[m];
      for (int s = 0; s < 6; s++) begin
        write_reg(CFG_STALE_AFTER, stale_set[s]);
        write_reg(CFG_FAIL_LIMIT, limit_set[s]);
        for (int n = 0; n < ITEMS_PER_SET; n++) send_item(random_item(), 0, '0);
        drain();
      end
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tsrq_pkg.sv
rtl/tsrq_check.sv
rtl/temp_sensor_reading_qualifier.sv
test/temp_sensor_reading_qualifier_tb.sv
